[rtl/rpvt_pkg.sv]
// Shared types, constants and arithmetic helpers for the rigid pose vector transform.
// No dependencies; imported by rpvt_front, rpvt_back and the top level.
package rpvt_pkg;

    // Coordinate word and derived widths
    localparam int CW   = 32;          // coordinate width, signed Q1.(CW-2)
    localparam int FRAC = CW - 2;      // fraction bits
    localparam int PW   = CW + 3;      // rounded signed product
    localparam int AW   = CW + 6;      // accumulator

    localparam logic signed [AW-1:0] Q_ONE = {{(AW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
    localparam logic signed [AW-1:0] Q_MAX = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] Q_MIN = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic [2*CW-1:0] HALF = {{(2*CW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

    // Function codes of an input item
    typedef logic [2:0] t_func;
    localparam t_func FN_REF_Q = 3'd0;
    localparam t_func FN_REF_T = 3'd1;
    localparam t_func FN_CUR_Q = 3'd2;
    localparam t_func FN_CUR_T = 3'd3;
    localparam t_func FN_POS   = 3'd4;
    localparam t_func FN_DIR   = 3'd5;

    // Command kinds after classification
    typedef enum logic [2:0] {
        K_REF_Q,
        K_REF_T,
        K_CUR_Q,
        K_CUR_T,
        K_POS,
        K_DIR,
        K_PASS
    } t_kind;

    typedef struct packed {
        logic [2:0]           func;
        logic signed [CW-1:0] comp_w;
        logic signed [CW-1:0] comp_x;
        logic signed [CW-1:0] comp_y;
        logic signed [CW-1:0] comp_z;
        logic                 is_meg;
    } t_in_item;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
    } t_out_item;

    typedef struct packed {
        t_kind                kind;
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cmd;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Clip an accumulator value to the coordinate range
    function automatic logic signed [CW-1:0] sat_cw(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = v;
        if (v > Q_MAX) begin
            r = Q_MAX;
        end else if (v < Q_MIN) begin
            r = Q_MIN;
        end
        return r[CW-1:0];
    endfunction

    // Round a product magnitude half away from zero and apply its sign
    function automatic logic signed [PW-1:0] round_prod(input logic [2*CW-1:0] mag,
                                                        input logic neg);
        logic [2*CW-1:0]      t;
        logic signed [PW-1:0] s;
        t = mag + HALF;
        s = $signed({1'b0, t[2*CW-1:FRAC]});
        return neg ? -s : s;
    endfunction

endpackage

[rtl/rpvt_front.sv]
// Front end: takes input transfers, classifies them and queues commands.
// Depends on rpvt_pkg.
module rpvt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rpvt_pkg::t_in_item i_in,
    output rpvt_pkg::t_q_head  o_head,
    input  logic               i_pop
);
    import rpvt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       s_cmd;
    logic       s_keep;
    logic       s_push;

    // Classify: unused codes are accepted and dropped
    always_comb begin
        s_cmd.w = i_in.comp_w;
        s_cmd.x = i_in.comp_x;
        s_cmd.y = i_in.comp_y;
        s_cmd.z = i_in.comp_z;
        s_keep  = 1'b1;
        s_cmd.kind = K_PASS;
        unique case (i_in.func)
            FN_REF_Q: s_cmd.kind = K_REF_Q;
            FN_REF_T: s_cmd.kind = K_REF_T;
            FN_CUR_Q: s_cmd.kind = K_CUR_Q;
            FN_CUR_T: s_cmd.kind = K_CUR_T;
            FN_POS:   s_cmd.kind = i_in.is_meg ? K_POS : K_PASS;
            FN_DIR:   s_cmd.kind = i_in.is_meg ? K_DIR : K_PASS;
            default:  s_keep = 1'b0;
        endcase
    end

    assign o_stall = (r_cnt == 2'd2);
    assign s_push  = i_valid && !o_stall && s_keep;
    assign n_cnt   = r_cnt + {1'b0, s_push} - {1'b0, i_pop};

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wp] <= s_cmd;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];

endmodule

[rtl/rpvt_back.sv]
// Back end: pose storage, matrix rebuild and vector transform on one shared multiplier.
// Depends on rpvt_pkg.
module rpvt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpvt_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output rpvt_pkg::t_out_item o_out
);
    import rpvt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_QREF = 9'b000000010,
        S_RREF = 9'b000000100,
        S_QCUR = 9'b000001000,
        S_RCUR = 9'b000010000,
        S_MAT  = 9'b000100000,
        S_OFF  = 9'b001000000,
        S_VEC  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;

    // Pose state and derived transform
    logic signed [CW-1:0] r_rq [4];
    logic signed [CW-1:0] r_cq [4];
    logic signed [CW-1:0] r_rt [3];
    logic signed [CW-1:0] r_ct [3];
    logic signed [CW-1:0] r_rm [9];
    logic signed [CW-1:0] r_ro [3];
    logic signed [CW-1:0] r_rr [9];
    logic signed [CW-1:0] r_rc [9];
    logic signed [PW-1:0] r_pq [9];
    logic signed [CW-1:0] r_v   [3];
    logic signed [CW-1:0] r_res [3];
    t_kind                r_kind;

    // Sequencer counters
    logic [3:0] r_step;
    logic [1:0] r_ci;
    logic [1:0] r_cj;
    logic [1:0] r_cm;
    logic       r_drain;

    // Multiplier stage
    logic [2*CW-1:0] r_prod;
    logic            r_neg;
    logic            r_pv;
    logic [3:0]      r_pk;
    logic [1:0]      r_pi;
    logic [1:0]      r_pj;
    logic [1:0]      r_pm;
    logic signed [AW-1:0] r_acc;

    logic                 r_out_valid;
    t_out_item            r_out;

    logic signed [CW-1:0] s_a;
    logic signed [CW-1:0] s_b;
    logic [CW-1:0]        s_ma;
    logic [CW-1:0]        s_mb;
    logic                 s_issue;
    logic                 s_last;
    logic signed [CW-1:0] s_qw;
    logic signed [CW-1:0] s_qx;
    logic signed [CW-1:0] s_qy;
    logic signed [CW-1:0] s_qz;
    logic signed [AW-1:0] s_p;
    logic signed [AW-1:0] s_init;
    logic signed [AW-1:0] s_sum;
    logic signed [AW-1:0] s_mat [9];
    logic                 s_out_free;

    function automatic logic [3:0] idx3(input logic [1:0] i, input logic [1:0] m);
        return 4'({i, 1'b0}) + 4'(i) + 4'(m);
    endfunction

    function automatic logic signed [AW-1:0] ext_p(input logic signed [PW-1:0] v);
        return AW'(v);
    endfunction

    function automatic logic signed [AW-1:0] ext_c(input logic signed [CW-1:0] v);
        return AW'(v);
    endfunction

    assign s_issue = !r_drain && (r_state == S_QREF || r_state == S_QCUR
                     || r_state == S_MAT || r_state == S_OFF || r_state == S_VEC);

    // Operand selection for the shared multiplier
    always_comb begin
        s_qw = (r_state == S_QREF) ? r_rq[0] : r_cq[0];
        s_qx = (r_state == S_QREF) ? r_rq[1] : r_cq[1];
        s_qy = (r_state == S_QREF) ? r_rq[2] : r_cq[2];
        s_qz = (r_state == S_QREF) ? r_rq[3] : r_cq[3];
        s_a  = r_rm[idx3(r_ci, r_cm)];
        s_b  = r_v[r_cm];
        s_last = (r_ci == 2'd2) && (r_cm == 2'd2);
        if (r_state == S_QREF || r_state == S_QCUR) begin
            s_last = (r_step == 4'd8);
            case (r_step)
                4'd0:    begin s_a = s_qx; s_b = s_qx; end
                4'd1:    begin s_a = s_qy; s_b = s_qy; end
                4'd2:    begin s_a = s_qz; s_b = s_qz; end
                4'd3:    begin s_a = s_qx; s_b = s_qy; end
                4'd4:    begin s_a = s_qx; s_b = s_qz; end
                4'd5:    begin s_a = s_qy; s_b = s_qz; end
                4'd6:    begin s_a = s_qw; s_b = s_qx; end
                4'd7:    begin s_a = s_qw; s_b = s_qy; end
                default: begin s_a = s_qw; s_b = s_qz; end
            endcase
        end else if (r_state == S_MAT) begin
            s_a    = r_rr[idx3(r_ci, r_cm)];
            s_b    = r_rc[idx3(r_cj, r_cm)];
            s_last = (r_ci == 2'd2) && (r_cj == 2'd2) && (r_cm == 2'd2);
        end else if (r_state == S_OFF) begin
            s_b = r_ct[r_cm];
        end
        s_ma = s_a[CW-1] ? CW'(-s_a) : CW'(s_a);
        s_mb = s_b[CW-1] ? CW'(-s_b) : CW'(s_b);
    end

    // Rounded product and running sum over one row
    always_comb begin
        s_p    = ext_p(round_prod(r_prod, r_neg));
        s_init = (r_pm == 2'd0) ? '0 : r_acc;
        if (r_state == S_VEC && r_pm == 2'd0 && r_kind == K_POS) begin
            s_init = ext_c(r_ro[r_pi]);
        end
        s_sum = s_init + s_p;
    end

    // Rotation matrix from the nine quaternion products
    always_comb begin
        s_mat[0] = Q_ONE - ((ext_p(r_pq[1]) + ext_p(r_pq[2])) <<< 1);
        s_mat[1] = (ext_p(r_pq[3]) - ext_p(r_pq[8])) <<< 1;
        s_mat[2] = (ext_p(r_pq[4]) + ext_p(r_pq[7])) <<< 1;
        s_mat[3] = (ext_p(r_pq[3]) + ext_p(r_pq[8])) <<< 1;
        s_mat[4] = Q_ONE - ((ext_p(r_pq[0]) + ext_p(r_pq[2])) <<< 1);
        s_mat[5] = (ext_p(r_pq[5]) - ext_p(r_pq[6])) <<< 1;
        s_mat[6] = (ext_p(r_pq[4]) - ext_p(r_pq[7])) <<< 1;
        s_mat[7] = (ext_p(r_pq[5]) + ext_p(r_pq[6])) <<< 1;
        s_mat[8] = Q_ONE - ((ext_p(r_pq[0]) + ext_p(r_pq[1])) <<< 1);
    end

    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign s_out_free = !r_out_valid || !i_stall;

    // Sequencer, pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_drain     <= 1'b0;
            r_step      <= '0;
            r_ci        <= '0;
            r_cj        <= '0;
            r_cm        <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_rq[k] <= (k == 0) ? Q_ONE[CW-1:0] : '0;
                r_cq[k] <= (k == 0) ? Q_ONE[CW-1:0] : '0;
            end
            for (int k = 0; k < 3; k++) begin
                r_rt[k] <= '0;
                r_ct[k] <= '0;
                r_ro[k] <= '0;
            end
            for (int k = 0; k < 9; k++) begin
                r_rm[k] <= (k == 0 || k == 4 || k == 8) ? Q_ONE[CW-1:0] : '0;
            end
        end else begin
            // multiplier issue
            r_pv <= s_issue;
            if (s_issue) begin
                r_prod <= s_ma * s_mb;
                r_neg  <= s_a[CW-1] ^ s_b[CW-1];
                r_pk   <= r_step;
                r_pi   <= r_ci;
                r_pj   <= r_cj;
                r_pm   <= r_cm;
                r_step <= r_step + 4'd1;
                if (r_cm == 2'd2) begin
                    r_cm <= '0;
                    if (r_state == S_MAT && r_cj != 2'd2) begin
                        r_cj <= r_cj + 2'd1;
                    end else begin
                        r_cj <= '0;
                        r_ci <= r_ci + 2'd1;
                    end
                end else begin
                    r_cm <= r_cm + 2'd1;
                end
                if (s_last) begin
                    r_drain <= 1'b1;
                end
            end

            // accumulate stage
            if (r_pv) begin
                r_acc <= s_sum;
                if (r_state == S_QREF || r_state == S_QCUR) begin
                    r_pq[r_pk] <= s_p[PW-1:0];
                end
                if (r_pm == 2'd2) begin
                    if (r_state == S_MAT) begin
                        r_rm[idx3(r_pi, r_pj)] <= sat_cw(s_sum);
                    end else if (r_state == S_OFF) begin
                        r_ro[r_pi] <= sat_cw(ext_c(r_rt[r_pi]) - s_sum);
                    end else if (r_state == S_VEC) begin
                        r_res[r_pi] <= sat_cw(s_sum);
                    end
                end
            end

            // output register: a transfer empties it unless a new result loads
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_step <= '0;
                        r_ci   <= '0;
                        r_cj   <= '0;
                        r_cm   <= '0;
                        r_kind <= i_head.cmd.kind;
                        case (i_head.cmd.kind)
                            K_REF_Q: begin
                                r_rq[0] <= i_head.cmd.w;
                                r_rq[1] <= i_head.cmd.x;
                                r_rq[2] <= i_head.cmd.y;
                                r_rq[3] <= i_head.cmd.z;
                                r_state <= S_QREF;
                            end
                            K_REF_T: begin
                                r_rt[0] <= i_head.cmd.x;
                                r_rt[1] <= i_head.cmd.y;
                                r_rt[2] <= i_head.cmd.z;
                                r_state <= S_QREF;
                            end
                            K_CUR_Q: begin
                                r_cq[0] <= i_head.cmd.w;
                                r_cq[1] <= i_head.cmd.x;
                                r_cq[2] <= i_head.cmd.y;
                                r_cq[3] <= i_head.cmd.z;
                                r_state <= S_QREF;
                            end
                            K_CUR_T: begin
                                r_ct[0] <= i_head.cmd.x;
                                r_ct[1] <= i_head.cmd.y;
                                r_ct[2] <= i_head.cmd.z;
                                r_state <= S_QREF;
                            end
                            K_POS, K_DIR: begin
                                r_v[0]  <= i_head.cmd.x;
                                r_v[1]  <= i_head.cmd.y;
                                r_v[2]  <= i_head.cmd.z;
                                r_state <= S_VEC;
                            end
                            default: begin
                                r_res[0] <= i_head.cmd.x;
                                r_res[1] <= i_head.cmd.y;
                                r_res[2] <= i_head.cmd.z;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_QREF, S_QCUR, S_MAT, S_OFF, S_VEC: begin
                    // drain cycle: last product lands, move on
                    if (r_drain) begin
                        r_drain <= 1'b0;
                        r_step  <= '0;
                        r_ci    <= '0;
                        r_cj    <= '0;
                        r_cm    <= '0;
                        case (r_state)
                            S_QREF:  r_state <= S_RREF;
                            S_QCUR:  r_state <= S_RCUR;
                            S_MAT:   r_state <= S_OFF;
                            S_OFF:   r_state <= S_IDLE;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RREF: begin
                    for (int k = 0; k < 9; k++) begin
                        r_rr[k] <= sat_cw(s_mat[k]);
                    end
                    r_state <= S_QCUR;
                end
                S_RCUR: begin
                    for (int k = 0; k < 9; k++) begin
                        r_rc[k] <= sat_cw(s_mat[k]);
                    end
                    r_state <= S_MAT;
                end
                S_DONE: begin
                    if (s_out_free) begin
                        r_out.out_x <= r_res[0];
                        r_out.out_y <= r_res[1];
                        r_out.out_z <= r_res[2];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

[rtl/rigid_pose_vector_transform_top.sv]
// Top level of the rigid pose vector transform: front end queue plus compute back end.
// Depends on rpvt_pkg, rpvt_front and rpvt_back.
//
// Usage:
//   Input channel (i_valid / o_stall / i_in) carries pose loads and vectors.
//   Codes 0..3 load the reference or current quaternion or translation and
//   produce no result; codes 4 and 5 produce one result on the output channel
//   (o_valid / i_stall / o_out). Codes 6 and 7 are taken and dropped.
//   A two-entry queue sits between the front end and the back end, so the
//   input keeps taking transfers while the back end computes or the output
//   waits, until the queue is full.
//   The back end owns one 32x32 multiplier, issuing one product a cycle within
//   each product run, with rounding and accumulation in the cycle after each issue.
//   A vector item goes from queue head to output register through a dequeue,
//   nine products, a drain and an output load. Pass-through items for
//   non-MEG channels go from the dequeue straight to the output load. A pose
//   load rebuilds both rotation matrices, the relative matrix and offset: 54 products.
//   Reset (synchronous, active low) empties the queue, drops any held result
//   and restores identity poses and an identity relative transform.
//   A stalled output holds its value; the back end then waits with its
//   finished result and the queue fills up to its two entries.
module rigid_pose_vector_transform_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rpvt_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output rpvt_pkg::t_out_item o_out
);
    import rpvt_pkg::*;

    t_q_head s_head;
    logic    s_pop;

    // Accept and classify
    rpvt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_head  (s_head),
        .i_pop   (s_pop)
    );

    // Compute and deliver
    rpvt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (s_head),
        .o_pop   (s_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    // The back end only dequeues a command that is present
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> s_head.valid)
        else $error("dequeue from empty queue");

    // A held result does not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output changed under stall");

    // Reset clears the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule

[tb/sv/tb_rigid_pose_vector_transform_top.sv]
// Testbench for the rigid pose vector transform: pose loads and sensor vectors in,
// transformed vectors out, checked against an in-bench fixed-point predictor.
// Depends on rpvt_pkg and rigid_pose_vector_transform_top.
`timescale 1ns / 1ps

module tb_rigid_pose_vector_transform_top;
    import rpvt_pkg::*;

    localparam longint QONE = 64'sd1 << 30;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    // Function codes with no meaning; the block drops them
    localparam t_func FN_SPARE_A = 3'd6;
    localparam t_func FN_SPARE_B = 3'd7;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_in;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_out;

    rigid_pose_vector_transform_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    // Predictor state
    longint    pose_ref_q[4];
    longint    pose_cur_q[4];
    longint    pose_ref_t[3];
    longint    pose_cur_t[3];
    longint    rel_rot[9];
    longint    rel_shift[3];
    t_out_item vec_expected[$];

    int  n_err;
    int  n_vec;
    int  n_pose;
    int  n_pass;
    bit  quiet_mode;     // no random idling on either side

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Fixed-point helpers
    function automatic longint clip(input longint v);
        if (v > QMAX) begin
            return QMAX;
        end
        if (v < QMIN) begin
            return QMIN;
        end
        return v;
    endfunction

    // Exact product rounded half away from zero to 30 fraction bits
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] ma, mb, p;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = ma * mb + (128'd1 << 29);
        p   = p >> 30;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    task automatic quat_rot(input longint q[4], output longint r[9]);
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        xx = fx_mul(q[1], q[1]); yy = fx_mul(q[2], q[2]); zz = fx_mul(q[3], q[3]);
        xy = fx_mul(q[1], q[2]); xz = fx_mul(q[1], q[3]); yz = fx_mul(q[2], q[3]);
        wx = fx_mul(q[0], q[1]); wy = fx_mul(q[0], q[2]); wz = fx_mul(q[0], q[3]);
        r[0] = clip(QONE - 2 * (yy + zz));
        r[1] = clip(2 * (xy - wz));
        r[2] = clip(2 * (xz + wy));
        r[3] = clip(2 * (xy + wz));
        r[4] = clip(QONE - 2 * (xx + zz));
        r[5] = clip(2 * (yz - wx));
        r[6] = clip(2 * (xz - wy));
        r[7] = clip(2 * (yz + wx));
        r[8] = clip(QONE - 2 * (xx + yy));
    endtask

    function automatic longint row_dot(input int i, input longint v[3]);
        return fx_mul(rel_rot[3*i], v[0]) + fx_mul(rel_rot[3*i+1], v[1])
             + fx_mul(rel_rot[3*i+2], v[2]);
    endfunction

    task automatic rebuild_relative();
        longint rr[9], rc[9];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rel_rot[3*i+j] = 0;
            end
        end
        quat_rot(pose_ref_q, rr);
        quat_rot(pose_cur_q, rc);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rel_rot[3*i+j] = clip(fx_mul(rr[3*i], rc[3*j])
                    + fx_mul(rr[3*i+1], rc[3*j+1]) + fx_mul(rr[3*i+2], rc[3*j+2]));
            end
        end
        for (int i = 0; i < 3; i++) begin
            rel_shift[i] = clip(pose_ref_t[i] - row_dot(i, pose_cur_t));
        end
    endtask

    task automatic pose_reset();
        for (int i = 0; i < 4; i++) begin
            pose_ref_q[i] = 0;
            pose_cur_q[i] = 0;
        end
        pose_ref_q[0] = QONE;
        pose_cur_q[0] = QONE;
        for (int i = 0; i < 3; i++) begin
            pose_ref_t[i] = 0;
            pose_cur_t[i] = 0;
            rel_shift[i]  = 0;
        end
        for (int i = 0; i < 9; i++) begin
            rel_rot[i] = (i % 4 == 0) ? QONE : 0;
        end
    endtask

    // Predict the effect of one accepted item
    task automatic predict_item(input t_in_item it);
        longint    v[3];
        longint    o[3];
        t_out_item r;
        v[0] = it.comp_x; v[1] = it.comp_y; v[2] = it.comp_z;
        case (it.func)
            FN_REF_Q: begin
                pose_ref_q[0] = it.comp_w;
                for (int i = 0; i < 3; i++) pose_ref_q[i+1] = v[i];
            end
            FN_CUR_Q: begin
                pose_cur_q[0] = it.comp_w;
                for (int i = 0; i < 3; i++) pose_cur_q[i+1] = v[i];
            end
            FN_REF_T: begin
                for (int i = 0; i < 3; i++) pose_ref_t[i] = v[i];
            end
            FN_CUR_T: begin
                for (int i = 0; i < 3; i++) pose_cur_t[i] = v[i];
            end
            default: ;
        endcase
        if (it.func <= FN_CUR_T) begin
            rebuild_relative();
            n_pose++;
        end else if (it.func == FN_POS || it.func == FN_DIR) begin
            for (int i = 0; i < 3; i++) begin
                if (!it.is_meg) begin
                    o[i] = v[i];
                end else begin
                    o[i] = row_dot(i, v);
                    if (it.func == FN_POS) o[i] += rel_shift[i];
                    o[i] = clip(o[i]);
                end
            end
            r.out_x = o[0][31:0];
            r.out_y = o[1][31:0];
            r.out_z = o[2][31:0];
            vec_expected.push_back(r);
            if (it.is_meg) n_vec++; else n_pass++;
        end
    endtask

    // Send one item and wait for its transfer; valid stays up for the next item
    task automatic send_item(input t_in_item it);
        while (!quiet_mode && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (vec_expected.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(input t_func f, input logic [31:0] w,
                                    input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic meg);
        t_in_item it;
        it.func = f; it.comp_w = w; it.comp_x = x; it.comp_y = y; it.comp_z = z;
        it.is_meg = meg;
        return it;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $urandom_range(32'h7fff_ffff) - 32'sh4000_0000;
        endcase
    endfunction

    // Quaternion with components of magnitude at most one half and random signs; occasionally wild
    function automatic t_in_item rnd_quat(input t_func f);
        logic [31:0] c[4];
        if ($urandom_range(9) == 0) begin
            return mk(f, $urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom()));
        end
        for (int i = 0; i < 4; i++) begin
            c[i] = $urandom_range(32'h2000_0000);
            if ($urandom_range(1)) c[i] = -c[i];
        end
        return mk(f, c[0], c[1], c[2], c[3], 1'($urandom()));
    endfunction

    // Receiver: random stall and result check
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (vec_expected.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("ERROR: unexpected result %h", o_out);
                end else begin
                    e = vec_expected.pop_front();
                    if (e !== o_out) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("ERROR: result mismatch exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                                     e.out_x, e.out_y, e.out_z,
                                     o_out.out_x, o_out.out_y, o_out.out_z);
                        end
                    end
                end
            end
            i_stall <= !quiet_mode && ($urandom_range(99) < 7);
        end
    end

    // Directed: extremes, every code, pass-through, unused codes, overflow
    task automatic test_directed();
        send_item(mk(FN_POS, 0, 32'h4000_0000, 32'h8000_0000, 32'h7fff_ffff, 1));
        send_item(mk(FN_DIR, 32'hffff_ffff, 32'h1234_5678, 0, 32'hc000_0000, 1));
        send_item(mk(FN_POS, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h5555_aaaa, 0));
        send_item(mk(FN_SPARE_A, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1));
        send_item(mk(FN_SPARE_B, 0, 5, 6, 7, 0));
        send_item(mk(FN_REF_T, 0, 32'h1000_0000, 32'hf000_0000, 32'h0800_0000, 1));
        send_item(mk(FN_POS, 0, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 1));
        send_item(mk(FN_REF_Q, 32'h2d41_3ccd, 0, 0, 32'h2d41_3ccd, 0));
        send_item(mk(FN_CUR_T, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 1));
        send_item(mk(FN_POS, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1));
        send_item(mk(FN_DIR, 0, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 1));
        // non-unit and extreme quaternions saturate matrix entries
        send_item(mk(FN_CUR_Q, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 1));
        send_item(mk(FN_POS, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1));
        send_item(mk(FN_REF_Q, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 0));
        send_item(mk(FN_DIR, 0, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 1));
        send_item(mk(FN_CUR_Q, 32'h4000_0000, 0, 0, 0, 1));
        send_item(mk(FN_REF_Q, 32'h4000_0000, 0, 0, 0, 1));
        send_item(mk(FN_REF_T, 0, 0, 0, 0, 0));
        send_item(mk(FN_CUR_T, 0, 0, 0, 0, 0));
        send_item(mk(FN_POS, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 0, 1));
    endtask

    // Random: pose segments followed by bursts of vectors, with some noise
    task automatic test_random(input int n_items);
        int       sent;
        t_in_item it;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(3))
                0: it = rnd_quat(FN_REF_Q);
                1: it = rnd_quat(FN_CUR_Q);
                2: it = mk(FN_REF_T, $urandom(), rnd_word() >>> 2, rnd_word() >>> 2,
                           rnd_word(), 1'($urandom()));
                default: it = mk(FN_CUR_T, $urandom(), rnd_word(), rnd_word() >>> 3,
                                 rnd_word() >>> 2, 1'($urandom()));
            endcase
            send_item(it);
            sent++;
            repeat ($urandom_range(30, 3)) begin
                if ($urandom_range(19) == 0) begin
                    it = mk(t_func'($urandom_range(7)), $urandom(), $urandom(),
                            $urandom(), $urandom(), 1'($urandom()));
                end else begin
                    it = mk($urandom_range(1) ? FN_POS : FN_DIR, $urandom(), rnd_word(),
                            rnd_word(), rnd_word(), $urandom_range(9) != 0);
                end
                send_item(it);
                if (it.func >= FN_POS && it.func <= FN_DIR) sent++;
            end
        end
    endtask

    // Back-to-back traffic with no idling, then a full pause
    task automatic test_pressure();
        quiet_mode = 1'b1;
        test_random(250);
        wait_drained();
        quiet_mode = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in       = '0;
        n_err      = 0;
        n_vec      = 0;
        n_pose     = 0;
        n_pass     = 0;
        quiet_mode = 1'b0;
        pose_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(700);
        test_pressure();
        test_random(750);
        wait_drained();
        $display("Run covered %0d pose loads, %0d transformed vectors, %0d pass-throughs.",
                 n_pose, n_vec, n_pass);
        $display("Mismatches found: %0d", n_err);
        if (n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule
